[design/sitda_pkg.sv]
// Shared types and constants for the signed integer to decimal ASCII converter.
// Depends on nothing; imported by the digit cell, the top level and the checker.
`default_nettype none

package sitda_pkg;

   localparam int unsigned DIGIT_W   = 4;
   localparam int unsigned CHAR_W    = 6;

   localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
   localparam logic [CHAR_W-1:0] ASCII_NINE  = 6'd57;
   localparam logic [CHAR_W-1:0] ASCII_MINUS = 6'd45;

   // What every digit cell does in a cycle.
   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_CLEAR  = 2'd1,
      CELL_DABBLE = 2'd2,
      CELL_MOVE   = 2'd3
   } cell_mode_type;

endpackage

`default_nettype wire

[design/sitda_cell.sv]
// One BCD digit cell of the conversion chain: shift-and-add-3 step, then digit shift-out.
// Depends on sitda_pkg.
`default_nettype none

module sitda_cell
   import sitda_pkg::*;
(
   input  wire                clock,
   input  var cell_mode_type  mode,
   input  wire                carry_in,     // bit from the cell below
   input  wire  [DIGIT_W-1:0] digit_below,  // digit of the cell below
   output logic               carry_out,    // bit to the cell above
   output logic [DIGIT_W-1:0] digit
);

   logic [DIGIT_W-1:0] digit_ff;
   logic [DIGIT_W-1:0] digit_in;
   logic [DIGIT_W-1:0] adj;

   always_comb begin
      adj = (digit_ff >= DABBLE_LIMIT) ? digit_ff + DABBLE_ADD : digit_ff;
      carry_out = adj[DIGIT_W-1];
      case (mode)
         CELL_HOLD:   digit_in = digit_ff;
         CELL_CLEAR:  digit_in = '0;
         CELL_DABBLE: digit_in = {adj[DIGIT_W-2:0], carry_in};
         CELL_MOVE:   digit_in = digit_below;
         default:     digit_in = digit_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign digit = digit_ff;

endmodule

`default_nettype wire

[design/signed_int_to_decimal_ascii.sv]
// Top level of the signed integer to decimal ASCII converter.
// Depends on sitda_pkg and sitda_cell.
//
// Usage:
//   req_*  : one transfer carries one two's complement integer in
//            req_tdata[VALUE_BITS-1:0]; bits above are ignored.
//   rsp_*  : one transfer per ASCII character, most significant first:
//            an optional '-', then the digits without leading zeros
//            (zero gives a single '0'). rsp_tlast marks the final character.
// Operation:
//   The magnitude is shifted MSB first through a row of BCD digit cells
//   (shift-and-add-3), one bit per cycle. The digit row then shifts up one
//   cell per cycle, pausing for the sign or while a digit waits on the output;
//   the top cell is either dropped as a leading zero or sent out. The sign
//   goes out during the conversion, or first in the shift-out if the output is busy.
// Flow control:
//   req_tready is high only when no item is in flight; the final character
//   may still wait in the output register while the next item is taken.
// Reset / stall:
//   Synchronous active-high reset empties the output register and returns
//   to idle. A stalled receiver holds the character in the output register
//   and, once a digit is due, freezes the digit row until the slot frees.
`default_nettype none

module signed_int_to_decimal_ascii
   import sitda_pkg::*;
#(
   parameter int unsigned VALUE_BITS = 32
)
(
   input  wire                       clock,
   input  wire                       reset,

   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  wire  [8*((VALUE_BITS+7)/8)-1:0] req_tdata,  // [VALUE_BITS-1:0] value

   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   output logic [7:0]                rsp_tdata,  // [5:0] char_code, [7:6] zero
   output logic                      rsp_tlast   // last character of the number
);

   // Decimal digits of 2^(VALUE_BITS-1): floor((bits-1)*log10(2)) + 1.
   localparam int unsigned NUM_DIGITS = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
   localparam int unsigned BIT_CNT_W  = $clog2(VALUE_BITS);
   localparam int unsigned DIG_CNT_W  = $clog2(NUM_DIGITS);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [VALUE_BITS-1:0] mag_ff, mag_in;
   logic [BIT_CNT_W-1:0]  bit_cnt_ff, bit_cnt_in;
   logic [DIG_CNT_W-1:0]  dig_cnt_ff, dig_cnt_in;
   logic                  sign_pend_ff, sign_pend_in;
   logic                  seen_ff, seen_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]     rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;

   cell_mode_type         cell_mode;
   logic [DIGIT_W-1:0]    digit_w [NUM_DIGITS];
   logic                  carry_w [NUM_DIGITS];

   logic [VALUE_BITS-1:0] raw;
   logic                  negative;
   logic [VALUE_BITS-1:0] magnitude;
   logic                  slot_free;
   logic [DIGIT_W-1:0]    top_digit;
   logic                  is_last;

   // Digit row: cell 0 is the least significant digit.
   assign carry_w[0] = mag_ff[VALUE_BITS-1];

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
      if (i == NUM_DIGITS - 1) begin : g_top
         sitda_cell u_cell (
            .clock       (clock),
            .mode        (cell_mode),
            .carry_in    (carry_w[i]),
            .digit_below (digit_w[i-1]),
            .carry_out   (),
            .digit       (digit_w[i])
         );
      end else if (i == 0) begin : g_bottom
         sitda_cell u_cell (
            .clock       (clock),
            .mode        (cell_mode),
            .carry_in    (carry_w[i]),
            .digit_below ('0),
            .carry_out   (carry_w[i+1]),
            .digit       (digit_w[i])
         );
      end else begin : g_mid
         sitda_cell u_cell (
            .clock       (clock),
            .mode        (cell_mode),
            .carry_in    (carry_w[i]),
            .digit_below (digit_w[i-1]),
            .carry_out   (carry_w[i+1]),
            .digit       (digit_w[i])
         );
      end
   end

   always_comb begin
      raw       = req_tdata[VALUE_BITS-1:0];
      negative  = raw[VALUE_BITS-1];
      // Most negative value negates to itself, which read unsigned is exact.
      magnitude = negative ? (~raw + 1'b1) : raw;
      slot_free = !rsp_valid_ff || rsp_tready;
      top_digit = digit_w[NUM_DIGITS-1];
      is_last   = (dig_cnt_ff == '0);

      state_in     = state_ff;
      mag_in       = mag_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_cnt_in   = dig_cnt_ff;
      sign_pend_in = sign_pend_ff;
      seen_in      = seen_ff;
      cell_mode    = CELL_HOLD;
      req_tready   = 1'b0;

      // Output register drains on a transfer unless refilled below.
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               mag_in       = magnitude;
               sign_pend_in = negative;
               bit_cnt_in   = BIT_CNT_W'(VALUE_BITS - 1);
               cell_mode    = CELL_CLEAR;
               state_in     = ST_CONV;
            end
         end
         ST_CONV: begin
            cell_mode = CELL_DABBLE;
            mag_in    = {mag_ff[VALUE_BITS-2:0], 1'b0};
            if (sign_pend_ff && slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_MINUS;
               rsp_last_in  = 1'b0;
               sign_pend_in = 1'b0;
            end
            if (bit_cnt_ff == '0) begin
               dig_cnt_in = DIG_CNT_W'(NUM_DIGITS - 1);
               seen_in    = 1'b0;
               state_in   = ST_EMIT;
            end else begin
               bit_cnt_in = bit_cnt_ff - 1'b1;
            end
         end
         ST_EMIT: begin
            if (sign_pend_ff) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = ASCII_MINUS;
                  rsp_last_in  = 1'b0;
                  sign_pend_in = 1'b0;
               end
            end else if (top_digit == '0 && !seen_ff && !is_last) begin
               // leading zero: drop it, no output slot needed
               cell_mode  = CELL_MOVE;
               dig_cnt_in = dig_cnt_ff - 1'b1;
            end else if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
               rsp_last_in  = is_last;
               seen_in      = 1'b1;
               cell_mode    = CELL_MOVE;
               if (is_last) begin
                  state_in = ST_IDLE;
               end else begin
                  dig_cnt_in = dig_cnt_ff - 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         bit_cnt_ff   <= '0;
         dig_cnt_ff   <= '0;
         sign_pend_ff <= 1'b0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         bit_cnt_ff   <= bit_cnt_in;
         dig_cnt_ff   <= dig_cnt_in;
         sign_pend_ff <= sign_pend_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      mag_ff      <= mag_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(8-CHAR_W){1'b0}}, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

`default_nettype wire

[design/sitda_checker.sv]
// Port-level checks for the signed integer to decimal ASCII converter, bound to the top.
// Depends on sitda_pkg and signed_int_to_decimal_ascii.
`default_nettype none

module sitda_checker
   import sitda_pkg::*;
(
   input wire       clock,
   input wire       reset,
   input wire       req_tvalid,
   input wire       req_tready,
   input wire       rsp_tvalid,
   input wire       rsp_tready,
   input wire [7:0] rsp_tdata,
   input wire       rsp_tlast
);

   // A stalled character holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled character changed or dropped");

   // Only '-' or a digit ever goes out, upper bits zero.
   a_rsp_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[7:6] == 2'b00 &&
                     (rsp_tdata[5:0] == ASCII_MINUS ||
                      (rsp_tdata[5:0] >= ASCII_ZERO && rsp_tdata[5:0] <= ASCII_NINE)))
      else $error("character code out of range");

   // The sign is never the final character.
   a_minus_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5:0] == ASCII_MINUS |-> !rsp_tlast)
      else $error("minus sign flagged last");

   // One item at a time: ready drops right after an input transfer.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input taken while an item is in flight");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("output valid after reset");

endmodule

bind signed_int_to_decimal_ascii sitda_checker u_sitda_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire
